>>> rtl/core/fqd_pkg.sv
// Shared constants, types and helpers for the queue with dump.
`timescale 1ns / 1ps

package fqd_pkg;

    localparam int DEPTH    = 32;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    // result buffer behind the storage read port
    localparam int OBUF_DEPTH = 4;
    localparam int OBUF_AW    = $clog2(OBUF_DEPTH);
    localparam int OBUF_CW    = $clog2(OBUF_DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_PUSH  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PRINT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DATA  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t               word;
        logic [STATUS_W-1:0] status;
        logic                last;
    } resp_t;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
    endfunction

endpackage

>>> rtl/core/fqd_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module fqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/fqd_obuf.sv
// Small result FIFO that decouples the storage read from the result channel.
`timescale 1ns / 1ps

module fqd_obuf (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push_valid,
    input  fqd_pkg::resp_t                    push_data,
    input  logic                              pop_ready,
    output logic                              out_valid,
    output fqd_pkg::resp_t                    out_data,
    output logic [fqd_pkg::OBUF_CW-1:0]       fill
);

    import fqd_pkg::*;

    resp_t              buf_mem [OBUF_DEPTH];
    logic [OBUF_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OBUF_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OBUF_CW-1:0] cnt_reg, cnt_next;
    logic               do_pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = buf_mem[rd_ptr_reg];
    assign fill      = cnt_reg;
    assign do_pop    = out_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push_valid) begin
            wr_ptr_next = (wr_ptr_reg == OBUF_AW'(OBUF_DEPTH - 1)) ? '0 : wr_ptr_reg + OBUF_AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == OBUF_AW'(OBUF_DEPTH - 1)) ? '0 : rd_ptr_reg + OBUF_AW'(1);
        end
        if (push_valid && !do_pop) begin
            cnt_next = cnt_reg + OBUF_CW'(1);
        end else if (!push_valid && do_pop) begin
            cnt_next = cnt_reg - OBUF_CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            buf_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/fifo_queue_with_dump.sv
// Top level: bounded word queue with push, pop, front, clear and dump requests.
//
//  Channel   Direction  tdata        tuser          tlast
//  s_axis    in         value[31:0]  mode[2:0]      -
//  m_axis    out        word[31:0]   status[1:0]    last
//
// One request is taken per cycle while no dump runs and the result FIFO has room.
// A dump of N stored words latches the head and count, then reads one word per cycle
// while the result FIFO has room, from the single read port of the storage RAM.
// Results pass the registered RAM read, then the result FIFO, on their way to m_axis.
// Reset clears indices, counts and flags only; storage needs no clearing pass.
// A stalled m_axis side fills the four-entry result FIFO, then holds s_axis_tready low.
`timescale 1ns / 1ps

module fifo_queue_with_dump (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fqd_pkg::WORD_W-1:0]      s_axis_tdata,   // [31:0] value
    input  logic [fqd_pkg::MODE_W-1:0]      s_axis_tuser,   // [2:0] mode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fqd_pkg::WORD_W-1:0]      m_axis_tdata,   // [31:0] word
    output logic [fqd_pkg::STATUS_W-1:0]    m_axis_tuser,   // [1:0] status
    output logic                            m_axis_tlast
);

    import fqd_pkg::*;

    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       head_reg, head_next;
    logic [AW-1:0]       tail_reg, tail_next;
    logic                busy_reg, busy_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       rem_reg, rem_next;

    logic                pend_reg, pend_next;
    logic                pend_rd_reg, pend_rd_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                pend_last_reg, pend_last_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_q;

    logic [OBUF_CW-1:0]  obuf_fill;
    logic [OBUF_CW:0]    obuf_used;
    logic                space;
    logic                accept;
    logic                q_empty;
    logic                q_full;
    resp_t               resp;
    resp_t               out_resp;

    // count results in flight so the buffer can never overflow
    assign obuf_used     = {1'b0, obuf_fill} + {{OBUF_CW{1'b0}}, pend_reg};
    assign space         = obuf_used < (OBUF_CW + 1)'(OBUF_DEPTH);
    assign s_axis_tready = !busy_reg && space;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_empty       = (count_reg == '0);
    assign q_full        = (count_reg == CW'(DEPTH));

    always_comb begin
        count_next       = count_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        busy_next        = busy_reg;
        idx_next         = idx_reg;
        rem_next         = rem_reg;
        pend_next        = 1'b0;
        pend_rd_next     = 1'b0;
        pend_status_next = ST_DATA;
        pend_last_next   = 1'b1;
        ram_we           = 1'b0;
        ram_waddr        = tail_reg;
        ram_raddr        = head_reg;

        if (busy_reg) begin
            // dump: one stored word per cycle while the buffer has room
            if (space) begin
                ram_raddr      = idx_reg;
                pend_next      = 1'b1;
                pend_rd_next   = 1'b1;
                pend_last_next = (rem_reg == CW'(1));
                idx_next       = next_slot(idx_reg);
                rem_next       = rem_reg - CW'(1);
                if (rem_reg == CW'(1)) begin
                    busy_next = 1'b0;
                end
            end
        end else if (accept) begin
            case (s_axis_tuser)
                MODE_PUSH: begin
                    if (q_full) begin
                        pend_next        = 1'b1;
                        pend_status_next = ST_FULL;
                    end else begin
                        ram_we     = 1'b1;
                        tail_next  = next_slot(tail_reg);
                        count_next = count_reg + CW'(1);
                    end
                end
                MODE_POP: begin
                    pend_next = 1'b1;
                    if (q_empty) begin
                        pend_status_next = ST_EMPTY;
                    end else begin
                        pend_rd_next = 1'b1;
                        head_next    = next_slot(head_reg);
                        count_next   = count_reg - CW'(1);
                    end
                end
                MODE_FRONT: begin
                    pend_next = 1'b1;
                    if (q_empty) begin
                        pend_status_next = ST_EMPTY;
                    end else begin
                        pend_rd_next = 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    if (q_empty) begin
                        pend_next        = 1'b1;
                        pend_status_next = ST_EMPTY;
                    end else begin
                        head_next  = '0;
                        tail_next  = '0;
                        count_next = '0;
                    end
                end
                MODE_PRINT: begin
                    if (q_empty) begin
                        pend_next        = 1'b1;
                        pend_status_next = ST_EMPTY;
                    end else begin
                        busy_next = 1'b1;
                        idx_next  = head_reg;
                        rem_next  = count_reg;
                    end
                end
                default: begin
                    // unused modes: drop the request
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            busy_reg  <= 1'b0;
            idx_reg   <= '0;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_rd_reg     <= pend_rd_next;
        pend_status_reg <= pend_status_next;
        pend_last_reg   <= pend_last_next;
    end

    fqd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign resp.word   = pend_rd_reg ? word_t'(ram_q) : word_t'(0);
    assign resp.status = pend_status_reg;
    assign resp.last   = pend_last_reg;

    fqd_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (pend_reg),
        .push_data  (resp),
        .pop_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_data   (out_resp),
        .fill       (obuf_fill)
    );

    assign m_axis_tdata = out_resp.word;
    assign m_axis_tuser = out_resp.status;
    assign m_axis_tlast = out_resp.last;

endmodule

>>> test/fifo_queue_with_dump_test.sv
// Self-checking bench for the word queue with dump: directed and random requests against a queue predictor.
`timescale 1ns / 1ps

module fifo_queue_with_dump_test;

    import fqd_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int TARGET_RANDOM  = 300;
    localparam int IDLE_PERCENT   = 19;
    localparam int HOLD_OFF_AT    = 60;
    localparam int HOLD_OFF_LEN   = 300;
    localparam int CALM_FIRST     = 150;
    localparam int CALM_LAST      = 230;
    localparam int TAIL_CYCLES    = 40;

    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        word_t             value;
    } request_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [WORD_W-1:0]     s_axis_tdata = '0;   // [31:0] value
    logic [MODE_W-1:0]     s_axis_tuser = '0;   // [2:0] mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [WORD_W-1:0]     m_axis_tdata;        // [31:0] word
    logic [STATUS_W-1:0]   m_axis_tuser;        // [1:0] status
    logic                  m_axis_tlast;

    fifo_queue_with_dump dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    request_t pending_requests[$];
    resp_t    expected_results[$];

    // predicted queue contents
    word_t          stored_words[DEPTH];
    logic [AW-1:0]  head_slot = '0;
    logic [AW-1:0]  tail_slot = '0;
    int             stored_count = 0;

    int  fill_guess = 0;
    int  random_requests = 0;
    int  requests_taken = 0;
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  request_taken = 1'b0;
    bit  mismatch_seen = 1'b0;

    wire calm = (requests_taken >= CALM_FIRST) && (requests_taken < CALM_LAST);

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [AW-1:0] step_slot(input logic [AW-1:0] slot);
        return (slot == AW'(DEPTH - 1)) ? '0 : slot + AW'(1);
    endfunction

    function automatic resp_t make_result(input word_t word, input logic [STATUS_W-1:0] status,
                                          input logic last);
        resp_t r;
        r.word   = word;
        r.status = status;
        r.last   = last;
        return r;
    endfunction

    task automatic predict_queue(input request_t req);
        logic [AW-1:0] slot;
        slot = head_slot;
        case (req.mode)
            MODE_PUSH: begin
                if (stored_count >= DEPTH) begin
                    expected_results.push_back(make_result('0, ST_FULL, 1'b1));
                end else begin
                    stored_words[tail_slot] = req.value;
                    tail_slot = step_slot(tail_slot);
                    stored_count++;
                end
            end
            MODE_POP, MODE_FRONT: begin
                if (stored_count == 0) begin
                    expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    expected_results.push_back(make_result(stored_words[head_slot], ST_DATA,
                                                           1'b1));
                    if (req.mode == MODE_POP) begin
                        head_slot = step_slot(head_slot);
                        stored_count--;
                    end
                end
            end
            MODE_CLEAR: begin
                if (stored_count == 0) begin
                    expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end else begin
                    head_slot = '0;
                    tail_slot = '0;
                    stored_count = 0;
                end
            end
            MODE_PRINT: begin
                if (stored_count == 0) begin
                    expected_results.push_back(make_result('0, ST_EMPTY, 1'b1));
                end
                for (int k = 0; k < stored_count; k++) begin
                    expected_results.push_back(make_result(stored_words[slot], ST_DATA,
                                                           k == stored_count - 1));
                    slot = step_slot(slot);
                end
            end
            default: ;
        endcase
    endtask

    task automatic queue_request(input logic [MODE_W-1:0] mode, input word_t value);
        request_t req;
        req.mode  = mode;
        req.value = value;
        pending_requests.push_back(req);
        if (mode <= MODE_PRINT) begin
            random_requests++;
        end
        // track the fill level so that bursts reach full and empty
        case (mode)
            MODE_PUSH:  if (fill_guess < DEPTH) fill_guess++;
            MODE_POP:   if (fill_guess > 0) fill_guess--;
            MODE_CLEAR: fill_guess = 0;
            default: ;
        endcase
    endtask

    function automatic word_t random_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // requests: offer at the falling edge, advance once the current one is taken
    always @(negedge aclk) begin : drive_requests
        request_t req;
        if (aresetn && (!s_axis_tvalid || request_taken)) begin
            if (pending_requests.size() != 0 &&
                (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                req = pending_requests.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= req.value;
                s_axis_tuser  <= req.mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // results: random back-pressure plus one long hold-off to fill the block
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && requests_taken >= HOLD_OFF_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_OFF_LEN;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    always @(posedge aclk) begin : watch_channels
        resp_t got;
        resp_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $realtime, cycle_count);
            $display("Mismatches found");
            $finish;
        end else if (!aresetn) begin
            request_taken <= 1'b0;
        end else begin
            request_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready) begin
                got = make_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
                if (expected_results.size() == 0) begin
                    mismatch_seen = 1'b1;
                    $display("%0t: result with none expected: word %h status %0d last %0b",
                             $realtime, got.word, got.status, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got.word !== want.word || got.status !== want.status ||
                        got.last !== want.last) begin
                        mismatch_seen = 1'b1;
                        $display("%0t: expected %h/%0d/%0b, got %h/%0d/%0b",
                                 $realtime, want.word, want.status, want.last,
                                 got.word, got.status, got.last);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_queue(request_t'{mode: s_axis_tuser, value: s_axis_tdata});
                requests_taken++;
            end
        end
    end

    initial begin
        int pick;

        // directed: empty cases, extreme words, every mode, spare modes
        queue_request(MODE_PRINT, '0);
        queue_request(MODE_POP, '0);
        queue_request(MODE_FRONT, '0);
        queue_request(MODE_CLEAR, '0);
        queue_request(MODE_PUSH, 32'h8000_0000);
        queue_request(MODE_PUSH, 32'h7fff_ffff);
        queue_request(MODE_PUSH, '0);
        queue_request(MODE_PUSH, '1);
        queue_request(MODE_PUSH, 32'h5555_5555);
        queue_request(MODE_PUSH, 32'haaaa_aaaa);
        queue_request(MODE_FRONT, '0);
        queue_request(MODE_PRINT, '0);
        queue_request(MODE_POP, '0);
        for (int m = MODE_SPARE_FIRST; m <= MODE_SPARE_LAST; m++) begin
            queue_request(MODE_W'(m), $urandom);
        end
        queue_request(MODE_PRINT, '0);
        queue_request(MODE_CLEAR, '0);
        queue_request(MODE_PRINT, '0);
        queue_request(MODE_PUSH, 32'h0000_0001);
        queue_request(MODE_POP, '0);
        queue_request(MODE_POP, '0);
        random_requests = 0;

        // random sequences: fill to full, drain to empty, dumps, clears, mixed noise
        while (random_requests < TARGET_RANDOM) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    while (fill_guess < DEPTH) begin
                        if ($urandom_range(0, 7) == 0) queue_request(MODE_FRONT, $urandom);
                        queue_request(MODE_PUSH, random_word());
                    end
                    repeat ($urandom_range(1, 3)) queue_request(MODE_PUSH, random_word());
                    if ($urandom_range(0, 1)) queue_request(MODE_PRINT, $urandom);
                end
                3, 4: begin
                    while (fill_guess > 0) begin
                        if ($urandom_range(0, 4) == 0) queue_request(MODE_FRONT, $urandom);
                        queue_request(MODE_POP, $urandom);
                    end
                    queue_request(MODE_POP, $urandom);
                end
                5, 6: begin
                    queue_request(MODE_PRINT, $urandom);
                    repeat ($urandom_range(0, 3)) queue_request(MODE_POP, $urandom);
                end
                7: begin
                    queue_request(MODE_CLEAR, $urandom);
                    if ($urandom_range(0, 1)) queue_request(MODE_CLEAR, $urandom);
                end
                default: begin
                    repeat ($urandom_range(4, 10)) begin
                        pick = $urandom_range(0, 19);
                        if (pick == 0)
                            queue_request(MODE_W'($urandom_range(MODE_SPARE_LAST,
                                                                 MODE_SPARE_FIRST)),
                                          $urandom);
                        else if (pick <= 8)
                            queue_request(MODE_PUSH, random_word());
                        else if (pick <= 12)
                            queue_request(MODE_POP, $urandom);
                        else if (pick <= 14)
                            queue_request(MODE_FRONT, $urandom);
                        else if (pick == 15)
                            queue_request(MODE_CLEAR, $urandom);
                        else if (pick <= 17)
                            queue_request(MODE_PRINT, $urandom);
                        else
                            queue_request(MODE_PUSH, random_word());
                    end
                end
            endcase
        end

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        // let any late result show up
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (!mismatch_seen && expected_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
